// File: hw/rtl/dll_pkg.sv
// Package with the command codes, status codes and sequencer states of the list block.
package dll_pkg;
  localparam int NODES_DEF = 64;
  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [3:0] {
    CMD_FIRST = 4'd0, CMD_NEXT = 4'd1, CMD_LAST = 4'd2, CMD_PREV = 4'd3,
    CMD_PUSH_FRONT = 4'd4, CMD_PUSH_BACK = 4'd5, CMD_PUSH_CUR = 4'd6,
    CMD_POP_FRONT = 4'd7, CMD_POP_BACK = 4'd8, CMD_POP_CUR = 4'd9,
    CMD_CLEAN = 4'd10
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0, ST_NOTHING = 2'd1, ST_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE, S_READ, S_EXEC, S_OUT
  } state_t;
endpackage

// File: hw/rtl/dll_if.sv
// Valid/ready channel interfaces for requests and results.
interface dll_in_if #(parameter int DW = 32);
  logic valid;
  logic ready;
  logic [3:0] cmd;
  logic [DW-1:0] value;
  modport source (output valid, cmd, value, input ready);
  modport sink (input valid, cmd, value, output ready);
endinterface

interface dll_out_if #(parameter int DW = 32);
  logic valid;
  logic ready;
  logic [DW-1:0] value_out;
  logic [1:0] status;
  modport source (output valid, value_out, status, input ready);
  modport sink (input valid, value_out, status, output ready);
endinterface

// File: hw/rtl/doubly_linked_list_cursor.sv
// Top level: doubly linked list with a cursor over a node memory.
// Sequence: a request is taken in IDLE, the node links are read in READ (with the payload
// of a next or prev target), the update and write-back run in EXEC, and the result is
// presented in OUT. Requests are handled one at a time: a new request is taken in IDLE
// only after the previous result has been accepted in OUT, so an output stall holds it off.
// Reset: head, tail, cursor and free head become null, the fresh count zero; no memory sweep.
module doubly_linked_list_cursor
  import dll_pkg::*;
#(
  parameter int NODES = NODES_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input logic clk,
  input logic rst_n,
  dll_in_if.sink in_ch,
  dll_out_if.source out_ch
);
  localparam int IW = $clog2(NODES + 1);
  localparam int AW = $clog2(NODES);
  localparam logic [IW-1:0] NIL = IW'(NODES);

  logic [DATA_WIDTH-1:0] pay_mem [NODES];
  logic [IW-1:0] nx_mem [NODES];
  logic [IW-1:0] pv_mem [NODES];

  state_t state_r, state_nxt;
  logic [IW-1:0] head_r, tail_r, cur_r, free_r, fresh_r;
  logic [IW-1:0] head_nxt, tail_nxt, cur_nxt, free_nxt, fresh_nxt;
  logic [3:0] cmd_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic [IW-1:0] c_r;
  logic [DATA_WIDTH-1:0] rd_pay;
  logic [IW-1:0] rd_nx, rd_pv, rd_fnx;
  logic [31:0] out_val_r, out_val_nxt;
  logic [1:0] out_st_r, out_st_nxt;
  logic [IW-1:0] c_sel;
  logic [DATA_WIDTH-1:0] tgt_pay;
  logic [AW-1:0] tgt_a;

  logic we_pay;
  logic [AW-1:0] a_pay;
  logic we0, we1, we2, we3;
  logic [AW-1:0] a0, a1, a2, a3;
  logic [IW-1:0] d0, d1, d2, d3;

  function automatic logic isn(input logic [IW-1:0] i);
    return i < NIL;
  endfunction

  function automatic logic [31:0] ext(input logic [DATA_WIDTH-1:0] v);
    logic [DATA_WIDTH+31:0] w;
    w = {32'd0, v};
    return w[31:0];
  endfunction

  always_comb begin
    case (in_ch.cmd)
      CMD_NEXT, CMD_PREV, CMD_PUSH_CUR, CMD_POP_CUR: c_sel = cur_r;
      CMD_LAST, CMD_PUSH_BACK, CMD_POP_BACK: c_sel = tail_r;
      CMD_CLEAN: c_sel = tail_r;
      default: c_sel = head_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_ch.valid) begin
      cmd_r <= in_ch.cmd;
      val_r <= in_ch.value;
      c_r <= c_sel;
      rd_pay <= pay_mem[c_sel[AW-1:0]];
      rd_nx <= nx_mem[c_sel[AW-1:0]];
      rd_pv <= pv_mem[c_sel[AW-1:0]];
      rd_fnx <= nx_mem[free_r[AW-1:0]];
    end
  end

  assign tgt_a = (cmd_r == CMD_PREV) ? rd_pv[AW-1:0] : rd_nx[AW-1:0];

  always_ff @(posedge clk) begin
    if (state_r == S_READ) tgt_pay <= pay_mem[tgt_a];
  end

  always_ff @(posedge clk) begin
    if (we_pay) pay_mem[a_pay] <= val_r;
    if (we0) nx_mem[a0] <= d0;
    if (we1) nx_mem[a1] <= d1;
    if (we2) pv_mem[a2] <= d2;
    if (we3) pv_mem[a3] <= d3;
  end

  always_comb begin
    case (state_r)
      S_IDLE: state_nxt = in_ch.valid ? S_READ : S_IDLE;
      S_READ: state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_OUT;
      S_OUT: state_nxt = out_ch.ready ? S_IDLE : S_OUT;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    logic [IW-1:0] n, c, cn, tgt;
    logic got, c_ok;
    head_nxt = head_r; tail_nxt = tail_r; cur_nxt = cur_r;
    free_nxt = free_r; fresh_nxt = fresh_r;
    out_val_nxt = out_val_r; out_st_nxt = out_st_r;
    we_pay = 1'b0; a_pay = '0;
    we0 = 1'b0; we1 = 1'b0; we2 = 1'b0; we3 = 1'b0;
    a0 = '0; a1 = '0; a2 = '0; a3 = '0;
    d0 = NIL; d1 = NIL; d2 = NIL; d3 = NIL;
    c = c_r;
    c_ok = isn(c);
    got = 1'b1;
    n = NIL;
    tgt = NIL;
    cn = c_ok ? rd_nx : NIL;
    if (isn(free_r)) n = free_r;
    else if (fresh_r < NIL) n = fresh_r;
    else got = 1'b0;
    if (state_r == S_EXEC) begin
      out_val_nxt = '0;
      out_st_nxt = ST_NOTHING;
      case (cmd_r)
        CMD_FIRST, CMD_LAST, CMD_NEXT, CMD_PREV: begin
          if (cmd_r == CMD_NEXT) tgt = cn;
          else if (cmd_r == CMD_PREV) tgt = c_ok ? rd_pv : NIL;
          else tgt = c;
          if (isn(tgt) && (cmd_r == CMD_FIRST || cmd_r == CMD_LAST)) begin
            cur_nxt = tgt;
            out_val_nxt = ext(rd_pay);
            out_st_nxt = ST_DONE;
          end else if (isn(tgt)) begin
            cur_nxt = tgt;
            out_val_nxt = ext(tgt_pay);
            out_st_nxt = ST_DONE;
          end
        end
        CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_PUSH_CUR: begin
          if (cmd_r == CMD_PUSH_BACK) cur_nxt = tail_r;
          if (cmd_r == CMD_PUSH_CUR && !c_ok) begin
            out_st_nxt = ST_NOTHING;
          end else if (!got) begin
            out_st_nxt = ST_FULL;
          end else begin
            out_st_nxt = ST_DONE;
            out_val_nxt = ext(val_r);
            if (isn(free_r)) free_nxt = rd_fnx;
            else fresh_nxt = fresh_r + 1'b1;
            we_pay = 1'b1; a_pay = n[AW-1:0];
            we0 = 1'b1; a0 = n[AW-1:0];
            we2 = 1'b1; a2 = n[AW-1:0];
            if (cmd_r == CMD_PUSH_FRONT || !c_ok) begin
              d0 = head_r;
              d2 = NIL;
              if (isn(head_r)) begin
                we3 = 1'b1; a3 = head_r[AW-1:0]; d3 = n;
              end else tail_nxt = n;
              head_nxt = n;
            end else begin
              d0 = cn;
              d2 = c;
              if (isn(cn)) begin
                we3 = 1'b1; a3 = cn[AW-1:0]; d3 = n;
              end else tail_nxt = n;
              we1 = 1'b1; a1 = c[AW-1:0]; d1 = n;
            end
          end
        end
        CMD_POP_FRONT, CMD_POP_BACK, CMD_POP_CUR: begin
          cur_nxt = c;
          if (c_ok) begin
            out_st_nxt = ST_DONE;
            out_val_nxt = ext(rd_pay);
            if (c == head_r) begin
              head_nxt = cn;
              if (isn(cn)) begin we2 = 1'b1; a2 = cn[AW-1:0]; d2 = NIL; end
            end else if (isn(rd_pv)) begin
              we1 = 1'b1; a1 = rd_pv[AW-1:0]; d1 = cn;
            end
            if (c == tail_r) begin
              tail_nxt = rd_pv;
              if (isn(rd_pv) && c != head_r) begin
                we1 = 1'b1; a1 = rd_pv[AW-1:0]; d1 = NIL;
              end else if (isn(rd_pv)) begin
                we1 = 1'b1; a1 = rd_pv[AW-1:0]; d1 = NIL;
              end
            end else if (isn(cn)) begin
              we3 = 1'b1; a3 = cn[AW-1:0]; d3 = rd_pv;
            end
            cur_nxt = cn;
            we0 = 1'b1; a0 = c[AW-1:0]; d0 = free_r;
            free_nxt = c;
          end
        end
        CMD_CLEAN: begin
          if (isn(head_r) && isn(tail_r)) begin
            we0 = 1'b1; a0 = tail_r[AW-1:0]; d0 = free_r;
            free_nxt = head_r;
          end
          head_nxt = NIL; tail_nxt = NIL; cur_nxt = NIL;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r <= NIL; tail_r <= NIL; cur_r <= NIL; free_r <= NIL; fresh_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r <= head_nxt; tail_r <= tail_nxt; cur_r <= cur_nxt;
      free_r <= free_nxt; fresh_r <= fresh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_st_r <= out_st_nxt;
    out_val_r <= out_val_nxt;
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.value_out = out_val_r;
  assign out_ch.status = out_st_r;

  a_nil_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == NIL) == (tail_r == NIL)) else $error("head/tail null mismatch");
  a_full_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != ST_DONE |-> out_ch.value_out == 32'd0)
    else $error("nonzero value with status");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.status))
    else $error("result dropped");
  a_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r <= NIL) else $error("fresh count overflow");
endmodule
